// File: rtl/core/absr_pkg.sv
// ----------------------------------------------------------------------------
// absr_pkg
// Shared types and constants for the adjacent block swap reorder block.
// ----------------------------------------------------------------------------
package absr_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned CFG_W  = 6;

	typedef enum logic {
		ST_ACCEPT,
		ST_DRAIN
	} absr_state_t;

endpackage : absr_pkg

// File: rtl/core/adjacent_block_swap_reorder.sv
// ----------------------------------------------------------------------------
// adjacent_block_swap_reorder
// Buffers pairs of word blocks and replays each complete pair swapped.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_axis_*, with s_axis_tlast marking the final word
//   of a list. Words are written into a 2*MAX_BLOCK entry buffer memory until
//   2*block_size words are held, then the pair is read back second block
//   first. A last word that does not complete a pair flushes what is held in
//   arrival order. m_axis_tuser flags the final word of each burst,
//   m_axis_tlast the final word of the list.
//   cfg_* writes block_size (saturated to 1..MAX_BLOCK) and drops any partly
//   filled pair; write it only while the block is idle.
// Flow:
//   Each burst word is read from the buffer memory and then loaded into the
//   output register; a new buffer read goes out only when no read data is
//   waiting for the output register and that register is free or being taken.
//   s_axis_tready is low while a burst is being read from the memory, so no
//   new word is taken until the whole burst has been read out.
// Reset clears the fill count and output valid and sets block_size to 1.
// A stalled receiver holds the output register and pauses the buffer reads.
// ----------------------------------------------------------------------------
module adjacent_block_swap_reorder
	import absr_pkg::*;
#(
	parameter int unsigned MAX_BLOCK = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration: block_size
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data,   // [5:0] block_size
	// input stream
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [WORD_W-1:0] s_axis_tdata,  // [31:0] word_in (signed)
	input  logic              s_axis_tlast,  // is_last
	// output stream
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [WORD_W-1:0] m_axis_tdata,  // [31:0] word_out (signed)
	output logic              m_axis_tuser,  // [0] run_end
	output logic              m_axis_tlast   // list_end
);

	localparam int unsigned DEPTH = 2 * MAX_BLOCK;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW    = $clog2(DEPTH + 1);
	localparam int unsigned BW    = $clog2(MAX_BLOCK + 1);
	localparam int unsigned XW    = CFG_W + 1;

	absr_state_t state_q, state_d;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_data_s1;

	logic [BW-1:0] bs_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic          swap_q;
	logic          last_q;

	logic rd_vld_s1, run_end_s1, list_end_s1;
	logic out_valid_q, out_run_end_q, out_list_end_q;
	logic [WORD_W-1:0] out_data_q;

	logic [CW-1:0] bs_ext, pair_len, fill_inc, rd_idx;
	logic [AW-1:0] rd_addr;
	logic          in_req, pair_done, issue, issue_last, out_load;
	logic [BW-1:0] cfg_bs;

	assign bs_ext    = CW'(bs_q);
	assign pair_len  = CW'({bs_q, 1'b0});
	assign fill_inc  = fill_q + CW'(1);
	assign pair_done = (fill_inc == pair_len);
	assign in_req    = s_axis_tvalid & s_axis_tready;

	// clamp the written block size into 1..MAX_BLOCK
	always_comb begin
		if (cfg_data == '0) begin
			cfg_bs = BW'(1);
		end else if (XW'(cfg_data) > XW'(MAX_BLOCK)) begin
			cfg_bs = BW'(MAX_BLOCK);
		end else begin
			cfg_bs = BW'(cfg_data);
		end
	end

	// swapped order: second block (bs..2bs-1), then first block (0..bs-1)
	always_comb begin
		if (!swap_q) begin
			rd_idx = idx_q;
		end else if (idx_q < bs_ext) begin
			rd_idx = idx_q + bs_ext;
		end else begin
			rd_idx = idx_q - bs_ext;
		end
	end
	assign rd_addr = rd_idx[AW-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_ACCEPT: begin
				if (in_req && (pair_done || s_axis_tlast)) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (issue && issue_last) state_d = ST_ACCEPT;
			end
			default: state_d = ST_ACCEPT;
		endcase
	end

	// outputs; a read goes out only when the output register will be free
	// for its data, so one read is in flight at most
	always_comb begin
		s_axis_tready = 1'b0;
		issue         = 1'b0;
		case (state_q)
			ST_ACCEPT: s_axis_tready = 1'b1;
			ST_DRAIN:  issue = !rd_vld_s1 && (!out_valid_q || m_axis_tready);
			default: begin
				s_axis_tready = 1'b0;
				issue         = 1'b0;
			end
		endcase
	end

	assign issue_last = (idx_q == cnt_q - CW'(1));
	assign out_load   = rd_vld_s1;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCEPT;
		end else begin
			state_q <= state_d;
		end
	end

	// buffer memory: writes only while accepting, reads only while draining
	always_ff @(posedge clk) begin
		if (in_req) begin
			mem[fill_q[AW-1:0]] <= s_axis_tdata;
		end
		if (issue) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q   <= BW'(1);
			fill_q <= '0;
			cnt_q  <= '0;
			idx_q  <= '0;
			swap_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				bs_q   <= cfg_bs;
				fill_q <= '0;
			end else if (in_req) begin
				last_q <= s_axis_tlast;
				idx_q  <= '0;
				if (pair_done) begin
					cnt_q  <= pair_len;
					swap_q <= 1'b1;
					fill_q <= '0;
				end else if (s_axis_tlast) begin
					cnt_q  <= fill_inc;
					swap_q <= 1'b0;
					fill_q <= '0;
				end else begin
					fill_q <= fill_inc;
				end
			end else if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			run_end_s1  <= 1'b0;
			list_end_s1 <= 1'b0;
		end else begin
			rd_vld_s1   <= issue;
			run_end_s1  <= issue_last;
			list_end_s1 <= issue_last & last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q     <= rd_data_s1;
			out_run_end_q  <= run_end_s1;
			out_list_end_q <= list_end_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_run_end_q;
	assign m_axis_tlast  = out_list_end_q;

	// read data must never land on a word the receiver has not taken
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (!out_valid_q || m_axis_tready))
		else $error("buffer read overran output register");

	// no buffer read past the end of the burst
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (idx_q < cnt_q))
		else $error("read index beyond burst length");

	// a partly filled pair never reaches the full pair length
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACCEPT) |-> (fill_q < pair_len))
		else $error("fill count out of range");

	// last word of a burst is flagged on the word that ends the read sequence
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && issue_last) |=> (rd_vld_s1 && run_end_s1))
		else $error("burst end flag lost");

endmodule : adjacent_block_swap_reorder
